// File: sv/fcd_pkg.sv
// Shared types and constants for the FLIC container deframer.
`default_nettype none

package fcd_pkg;

  localparam logic [15:0] MagicFli      = 16'hAF11;
  localparam logic [15:0] MagicFlc      = 16'hAF12;
  localparam logic [15:0] MagicFrame    = 16'hF1FA;
  localparam logic [15:0] MagicPrefix   = 16'hF5FA;
  localparam logic [7:0]  HeaderLastPos = 8'd127;
  localparam logic [7:0]  ShortDecPos   = 8'd17;
  localparam logic [31:0] PreambleLen   = 32'd6;
  localparam logic [9:0]  RateSlow      = 10'd15;
  localparam logic [9:0]  RateFli       = 10'd70;
  localparam logic [9:0]  RateFlc       = 10'd1000;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PhHeader   = 2'd0,
    PhPreamble = 2'd1,
    PhBody     = 2'd2,
    PhHalt     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindChunk  = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FaultNone  = 2'd0,
    FaultDim   = 2'd1,
    FaultMagic = 2'd2,
    FaultSize  = 2'd3
  } fault_e;

  typedef struct packed {
    logic            has_hdr;
    logic            has_err;
    logic            has_pre;
    logic            has_byte;
    logic [9:0]      rate;
    logic [15:0]     width;
    logic [15:0]     height;
    logic [31:0]     duration;
    fault_e          fault;
    logic [5:0][7:0] pre;
    logic [7:0]      data;
    logic            last;
    logic [63:0]     pts;
  } fcd_entry_t;

endpackage

`default_nettype wire

// File: sv/fcd_front.sv
// Front end: parses the file byte stream and queues output work entries.
`default_nettype none

module fcd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               q_ready_i,
  input  logic [7:0]         data_byte_i,
  input  logic               starts_file_i,
  output logic               push_o,
  output fcd_pkg::fcd_entry_t entry_o
);

  fcd_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [7:0]      hpos_q, hpos_d, cur_hpos;
  logic [15:0]     magic_q, magic_n, cur_magic;
  logic [15:0]     width_q, width_n, cur_width;
  logic [15:0]     height_q, height_n, cur_height;
  logic [31:0]     speed_q, speed_n, cur_speed;
  logic [5:0][7:0] buf_q, buf_n;
  logic [2:0]      ppos_q, ppos_d, cur_ppos;
  logic [31:0]     left_q, left_d, cur_left;
  logic            fwd_q, fwd_d, cur_fwd;
  logic [31:0]     dur_q, dur_d, cur_dur;
  logic [63:0]     pts_q, pts_d, cur_pts;

  logic        accept;
  logic [31:0] size;
  logic [15:0] pmagic;
  logic        hdr_short, hdr_long, dim_zero, magic_bad;
  logic        pre_end_p, size_small, size_six, frame_fwd, body_end;
  logic [31:0] long_dur;
  logic [9:0]  long_rate;

  assign accept = in_valid_i && q_ready_i;

  // Restart view and byte capture.
  always_comb begin
    cur_phase  = starts_file_i ? fcd_pkg::PhHeader : phase_q;
    cur_hpos   = starts_file_i ? 8'd0  : hpos_q;
    cur_magic  = starts_file_i ? 16'd0 : magic_q;
    cur_width  = starts_file_i ? 16'd0 : width_q;
    cur_height = starts_file_i ? 16'd0 : height_q;
    cur_speed  = starts_file_i ? 32'd0 : speed_q;
    cur_ppos   = starts_file_i ? 3'd0  : ppos_q;
    cur_left   = starts_file_i ? 32'd0 : left_q;
    cur_fwd    = starts_file_i ? 1'b0  : fwd_q;
    cur_dur    = starts_file_i ? 32'd0 : dur_q;
    cur_pts    = starts_file_i ? 64'd0 : pts_q;

    magic_n  = cur_magic;
    width_n  = cur_width;
    height_n = cur_height;
    speed_n  = cur_speed;
    buf_n    = buf_q;

    if (cur_phase == fcd_pkg::PhHeader) begin
      case (cur_hpos)
        8'd4:  magic_n[7:0]    = data_byte_i;
        8'd5:  magic_n[15:8]   = data_byte_i;
        8'd8:  width_n[7:0]    = data_byte_i;
        8'd9:  width_n[15:8]   = data_byte_i;
        8'd10: height_n[7:0]   = data_byte_i;
        8'd11: height_n[15:8]  = data_byte_i;
        8'd12: buf_n[0]        = data_byte_i;
        8'd13: buf_n[1]        = data_byte_i;
        8'd14: buf_n[2]        = data_byte_i;
        8'd15: buf_n[3]        = data_byte_i;
        8'd16: begin
          speed_n[7:0] = data_byte_i;
          buf_n[4]     = data_byte_i;
        end
        8'd17: begin
          speed_n[15:8] = data_byte_i;
          buf_n[5]      = data_byte_i;
        end
        8'd18: speed_n[23:16] = data_byte_i;
        8'd19: speed_n[31:24] = data_byte_i;
        default: ;
      endcase
    end

    if (cur_phase == fcd_pkg::PhPreamble) begin
      case (cur_ppos)
        3'd0: buf_n[0] = data_byte_i;
        3'd1: buf_n[1] = data_byte_i;
        3'd2: buf_n[2] = data_byte_i;
        3'd3: buf_n[3] = data_byte_i;
        3'd4: buf_n[4] = data_byte_i;
        3'd5: buf_n[5] = data_byte_i;
        default: ;
      endcase
    end

    size   = {buf_n[3], buf_n[2], buf_n[1], buf_n[0]};
    pmagic = {buf_n[5], buf_n[4]};

    hdr_short = (cur_phase == fcd_pkg::PhHeader) && (cur_hpos == fcd_pkg::ShortDecPos)
                && (speed_n[15:0] == fcd_pkg::MagicFrame);
    hdr_long  = (cur_phase == fcd_pkg::PhHeader) && (cur_hpos == fcd_pkg::HeaderLastPos);
    dim_zero  = (width_n == 16'd0) || (height_n == 16'd0);
    magic_bad = (magic_n != fcd_pkg::MagicFli) && (magic_n != fcd_pkg::MagicFlc);
    long_dur  = (speed_n == 32'd0) ? 32'd1 : speed_n;
    long_rate = (speed_n == 32'd0) ? fcd_pkg::RateSlow :
                (magic_n == fcd_pkg::MagicFli) ? fcd_pkg::RateFli : fcd_pkg::RateFlc;

    pre_end_p  = (cur_phase == fcd_pkg::PhPreamble) && (cur_ppos >= 3'd5);
    size_small = size < fcd_pkg::PreambleLen;
    size_six   = size == fcd_pkg::PreambleLen;
    frame_fwd  = ((pmagic == fcd_pkg::MagicFrame) || (pmagic == fcd_pkg::MagicPrefix))
                 && (size > fcd_pkg::PreambleLen);
    body_end   = (cur_phase == fcd_pkg::PhBody) && (cur_left <= 32'd1);
  end

  // Next state.
  always_comb begin
    phase_d = cur_phase;
    hpos_d  = cur_hpos;
    ppos_d  = cur_ppos;
    left_d  = cur_left;
    fwd_d   = cur_fwd;
    dur_d   = cur_dur;
    pts_d   = cur_pts;

    unique case (cur_phase)
      fcd_pkg::PhHeader: begin
        hpos_d = cur_hpos + 8'd1;
        if (hdr_short) begin
          if (dim_zero) begin
            phase_d = fcd_pkg::PhHalt;
          end else begin
            dur_d  = 32'd1;
            ppos_d = 3'd0;
            if (size_small) begin
              phase_d = fcd_pkg::PhHalt;
            end else if (frame_fwd) begin
              left_d  = size - fcd_pkg::PreambleLen;
              fwd_d   = 1'b1;
              phase_d = fcd_pkg::PhBody;
            end else if (size_six) begin
              phase_d = fcd_pkg::PhPreamble;
            end else begin
              left_d  = size - fcd_pkg::PreambleLen;
              fwd_d   = 1'b0;
              phase_d = fcd_pkg::PhBody;
            end
          end
        end else if (hdr_long) begin
          if (dim_zero || magic_bad) begin
            phase_d = fcd_pkg::PhHalt;
          end else begin
            dur_d   = long_dur;
            ppos_d  = 3'd0;
            phase_d = fcd_pkg::PhPreamble;
          end
        end
      end
      fcd_pkg::PhPreamble: begin
        ppos_d = cur_ppos + 3'd1;
        if (pre_end_p) begin
          ppos_d = 3'd0;
          if (size_small) begin
            phase_d = fcd_pkg::PhHalt;
          end else if (frame_fwd) begin
            left_d  = size - fcd_pkg::PreambleLen;
            fwd_d   = 1'b1;
            phase_d = fcd_pkg::PhBody;
          end else if (size_six) begin
            phase_d = fcd_pkg::PhPreamble;
          end else begin
            left_d  = size - fcd_pkg::PreambleLen;
            fwd_d   = 1'b0;
            phase_d = fcd_pkg::PhBody;
          end
        end
      end
      fcd_pkg::PhBody: begin
        left_d = (cur_left != 32'd0) ? cur_left - 32'd1 : 32'd0;
        if (body_end) begin
          if (cur_fwd) begin
            pts_d = cur_pts + {32'd0, cur_dur};
          end
          fwd_d   = 1'b0;
          ppos_d  = 3'd0;
          phase_d = fcd_pkg::PhPreamble;
        end
      end
      fcd_pkg::PhHalt: ;
      default: ;
    endcase
  end

  // Queue entry.
  always_comb begin
    entry_o          = '0;
    entry_o.pre      = buf_n;
    entry_o.data     = data_byte_i;
    entry_o.last     = cur_left <= 32'd1;
    entry_o.pts      = cur_pts;
    entry_o.width    = width_n;
    entry_o.height   = height_n;
    entry_o.rate     = long_rate;
    entry_o.duration = long_dur;
    entry_o.fault    = fcd_pkg::FaultNone;

    unique case (cur_phase)
      fcd_pkg::PhHeader: begin
        if (hdr_short) begin
          if (dim_zero) begin
            entry_o.has_err = 1'b1;
            entry_o.fault   = fcd_pkg::FaultDim;
          end else begin
            entry_o.has_hdr  = 1'b1;
            entry_o.rate     = fcd_pkg::RateSlow;
            entry_o.duration = 32'd1;
            if (size_small) begin
              entry_o.has_err = 1'b1;
              entry_o.fault   = fcd_pkg::FaultSize;
            end else if (frame_fwd) begin
              entry_o.has_pre = 1'b1;
            end
          end
        end else if (hdr_long) begin
          if (dim_zero) begin
            entry_o.has_err = 1'b1;
            entry_o.fault   = fcd_pkg::FaultDim;
          end else if (magic_bad) begin
            entry_o.has_err = 1'b1;
            entry_o.fault   = fcd_pkg::FaultMagic;
          end else begin
            entry_o.has_hdr = 1'b1;
          end
        end
      end
      fcd_pkg::PhPreamble: begin
        if (pre_end_p) begin
          if (size_small) begin
            entry_o.has_err = 1'b1;
            entry_o.fault   = fcd_pkg::FaultSize;
          end else if (frame_fwd) begin
            entry_o.has_pre = 1'b1;
          end
        end
      end
      fcd_pkg::PhBody: entry_o.has_byte = cur_fwd;
      fcd_pkg::PhHalt: ;
      default: ;
    endcase

    push_o = accept && (entry_o.has_hdr || entry_o.has_err
                        || entry_o.has_pre || entry_o.has_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fcd_pkg::PhHeader;
      hpos_q   <= '0;
      magic_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      speed_q  <= '0;
      ppos_q   <= '0;
      left_q   <= '0;
      fwd_q    <= 1'b0;
      dur_q    <= '0;
      pts_q    <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      magic_q  <= magic_n;
      width_q  <= width_n;
      height_q <= height_n;
      speed_q  <= speed_n;
      ppos_q   <= ppos_d;
      left_q   <= left_d;
      fwd_q    <= fwd_d;
      dur_q    <= dur_d;
      pts_q    <= pts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= buf_n;
    end
  end

endmodule

`default_nettype wire

// File: sv/fcd_queue.sv
// Short register FIFO of work entries between the front and back ends.
`default_nettype none

module fcd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fcd_pkg::fcd_entry_t push_entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output fcd_pkg::fcd_entry_t head_o
);

  fcd_pkg::fcd_entry_t               mem_q [fcd_pkg::QDepth];
  logic [fcd_pkg::QPtrW-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [fcd_pkg::QCntW-1:0]         cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = cnt_q == fcd_pkg::QCntW'(fcd_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/fcd_back.sv
// Back end: expands queued entries into result words on the output register.
`default_nettype none

module fcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  fcd_pkg::fcd_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          chunk_byte_o,
  output logic                last_of_chunk_o,
  output logic [63:0]         frame_pts_o,
  output logic [9:0]          tick_rate_o,
  output logic [15:0]         frame_width_o,
  output logic [15:0]         frame_height_o,
  output logic [31:0]         ticks_per_frame_o
  ,
  output logic [1:0]          fault_o
);

  logic        valid_q, valid_d;
  logic [2:0]  step_q, step_d;
  logic [2:0]  total, base, idx;
  logic        load, last_step;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [63:0] pts_q, pts_d;
  logic [9:0]  rate_q, rate_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [31:0] dur_q, dur_d;
  logic [1:0]  fault_q, fault_d;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    base  = {2'b00, q_entry_i.has_hdr};
    total = base + {2'b00, q_entry_i.has_err} + (q_entry_i.has_pre ? 3'd6 : 3'd0)
            + {2'b00, q_entry_i.has_byte};
    idx       = step_q - base;
    last_step = step_q == (total - 3'd1);

    kind_d   = fcd_pkg::KindHeader;
    byte_d   = '0;
    last_d   = 1'b0;
    pts_d    = '0;
    rate_d   = '0;
    width_d  = '0;
    height_d = '0;
    dur_d    = '0;
    fault_d  = fcd_pkg::FaultNone;

    if (q_entry_i.has_hdr && (step_q == 3'd0)) begin
      kind_d   = fcd_pkg::KindHeader;
      rate_d   = q_entry_i.rate;
      width_d  = q_entry_i.width;
      height_d = q_entry_i.height;
      dur_d    = q_entry_i.duration;
    end else if (q_entry_i.has_err) begin
      kind_d  = fcd_pkg::KindError;
      fault_d = q_entry_i.fault;
    end else if (q_entry_i.has_pre) begin
      kind_d = fcd_pkg::KindChunk;
      pts_d  = q_entry_i.pts;
      case (idx)
        3'd0: byte_d = q_entry_i.pre[0];
        3'd1: byte_d = q_entry_i.pre[1];
        3'd2: byte_d = q_entry_i.pre[2];
        3'd3: byte_d = q_entry_i.pre[3];
        3'd4: byte_d = q_entry_i.pre[4];
        3'd5: byte_d = q_entry_i.pre[5];
        default: byte_d = '0;
      endcase
    end else begin
      kind_d = fcd_pkg::KindChunk;
      byte_d = q_entry_i.data;
      last_d = q_entry_i.last;
      pts_d  = q_entry_i.pts;
    end

    valid_d = valid_q;
    step_d  = step_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        if (last_step) begin
          q_pop_o = 1'b1;
          step_d  = 3'd0;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
      pts_q    <= pts_d;
      rate_q   <= rate_d;
      width_q  <= width_d;
      height_q <= height_d;
      dur_q    <= dur_d;
      fault_q  <= fault_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign chunk_byte_o      = byte_q;
  assign last_of_chunk_o   = last_q;
  assign frame_pts_o       = pts_q;
  assign tick_rate_o       = rate_q;
  assign frame_width_o     = width_q;
  assign frame_height_o    = height_q;
  assign ticks_per_frame_o = dur_q;
  assign fault_o           = fault_q;

endmodule

`default_nettype wire

// File: sv/flic_container_deframer.sv
// Top level of the FLIC container deframer: parser, work queue and output sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid_i/in_ready_o | data_byte_i, starts_file_i
//   out     | output    | out_valid_o/out_ready_i | kind_o .. fault_o (one result word)
//
// One file byte is taken per cycle while the four-entry work queue has room.
// The output register sends one word per cycle while out_ready_i is high; a chunk
// preamble yields six words (seven with the header info), so the queue fills during
// those bursts. Input and output stall independently; only a full queue holds off
// the input. Reset clears parser state, queue pointers and the output valid;
// starts_file_i restarts parsing on its own byte.
`default_nettype none

module flic_container_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        starts_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  chunk_byte_o,
  output logic        last_of_chunk_o,
  output logic [63:0] frame_pts_o,
  output logic [9:0]  tick_rate_o,
  output logic [15:0] frame_width_o,
  output logic [15:0] frame_height_o,
  output logic [31:0] ticks_per_frame_o,
  output logic [1:0]  fault_o
);

  logic                q_full, q_valid, q_push, q_pop;
  fcd_pkg::fcd_entry_t push_entry, head_entry;

  assign in_ready_o = !q_full;

  fcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .q_ready_i    (in_ready_o),
    .data_byte_i  (data_byte_i),
    .starts_file_i(starts_file_i),
    .push_o       (q_push),
    .entry_o      (push_entry)
  );

  fcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      (head_entry)
  );

  fcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (head_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .chunk_byte_o     (chunk_byte_o),
    .last_of_chunk_o  (last_of_chunk_o),
    .frame_pts_o      (frame_pts_o),
    .tick_rate_o      (tick_rate_o),
    .frame_width_o    (frame_width_o),
    .frame_height_o   (frame_height_o),
    .ticks_per_frame_o(ticks_per_frame_o),
    .fault_o          (fault_o)
  );

endmodule

`default_nettype wire

// File: tb/flic_container_deframer_tb.sv
// Self-checking testbench for flic_container_deframer: byte-stream stimulus against a predictor.
module flic_container_deframer_tb;
  import fcd_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int BodyCap    = 24;
  localparam int HoldCycles = 150;
  localparam int NumRows    = 13;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        is_last;
    logic [63:0] pts;
    logic [9:0]  rate;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] ticks;
    fault_e      fault;
  } deframe_word_t;

  typedef struct packed {
    logic        short_hdr;
    logic [15:0] fmagic;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] spd;
    logic [31:0] size_a;
    logic [15:0] mag_a;
    logic [31:0] size_b;
    logic [15:0] mag_b;
    logic [31:0] size_c;
    logic [15:0] mag_c;
    kind_e       exp_kind;
    logic [9:0]  exp_rate;
    logic [31:0] exp_ticks;
    fault_e      exp_fault;
  } file_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        starts_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  chunk_byte_o;
  logic        last_of_chunk_o;
  logic [63:0] frame_pts_o;
  logic [9:0]  tick_rate_o;
  logic [15:0] frame_width_o;
  logic [15:0] frame_height_o;
  logic [31:0] ticks_per_frame_o;
  logic [1:0]  fault_o;

  flic_container_deframer u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .starts_file_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .chunk_byte_o,
    .last_of_chunk_o,
    .frame_pts_o,
    .tick_rate_o,
    .frame_width_o,
    .frame_height_o,
    .ticks_per_frame_o,
    .fault_o
  );

  always #6 clk_i = ~clk_i;

  deframe_word_t pending_words[$];
  deframe_word_t seen_exp;
  deframe_word_t typed_word;
  logic [7:0]    stream_b[$];
  bit            stream_sof[$];
  int            typed_idx = -1;
  int            send_idle = 0;
  int            recv_idle = 0;
  bit            hold_req = 1'b0;
  int            fail_cnt = 0;
  int            cycle_cnt = 0;
  file_row_t     dir_rows [NumRows];

  logic [7:0]      pr_hdr_idx;
  logic [15:0]     pr_fmagic;
  logic [15:0]     pr_width;
  logic [15:0]     pr_height;
  logic [31:0]     pr_speed;
  phase_e          pr_phase;
  logic [5:0][7:0] pr_pre;
  logic [2:0]      pr_pre_idx;
  logic [31:0]     pr_remain;
  logic            pr_fwd;
  logic [31:0]     pr_ticks;
  logic [63:0]     pr_pts;
  logic [9:0]      pr_rate;

  task automatic pr_reset();
    pr_hdr_idx = '0;
    pr_fmagic  = '0;
    pr_width   = '0;
    pr_height  = '0;
    pr_speed   = '0;
    pr_phase   = PhHeader;
    pr_pre     = '0;
    pr_pre_idx = '0;
    pr_remain  = '0;
    pr_fwd     = 1'b0;
    pr_ticks   = '0;
    pr_pts     = '0;
    pr_rate    = '0;
  endtask

  task automatic push_fault(input fault_e code);
    deframe_word_t w;
    w = '0;
    w.kind = KindError;
    w.fault = code;
    pending_words.push_back(w);
    pr_phase = PhHalt;
  endtask

  task automatic push_header();
    deframe_word_t w;
    w = '0;
    w.kind = KindHeader;
    w.rate = pr_rate;
    w.width = pr_width;
    w.height = pr_height;
    w.ticks = pr_ticks;
    pending_words.push_back(w);
    pr_phase = PhPreamble;
    pr_pre_idx = '0;
  endtask

  task automatic push_chunk_byte(input logic [7:0] b, input logic is_last);
    deframe_word_t w;
    w = '0;
    w.kind = KindChunk;
    w.data = b;
    w.is_last = is_last;
    w.pts = pr_pts;
    pending_words.push_back(w);
  endtask

  task automatic finish_preamble();
    logic [31:0] csize;
    logic [15:0] cmagic;
    int i;
    csize = pr_pre[3:0];
    cmagic = pr_pre[5:4];
    pr_pre_idx = '0;
    if (csize < PreambleLen) begin
      push_fault(FaultSize);
    end else if ((cmagic == MagicFrame || cmagic == MagicPrefix) && csize > PreambleLen) begin
      for (i = 0; i < 6; i++) push_chunk_byte(pr_pre[i], 1'b0);
      pr_remain = csize - PreambleLen;
      pr_fwd = 1'b1;
      pr_phase = PhBody;
    end else if (csize == PreambleLen) begin
      pr_phase = PhPreamble;
    end else begin
      pr_remain = csize - PreambleLen;
      pr_fwd = 1'b0;
      pr_phase = PhBody;
    end
  endtask

  task automatic predict_deframe(input logic [7:0] b, input bit sof);
    logic [7:0] p;
    logic       is_last;
    if (sof) pr_reset();
    case (pr_phase)
      PhHeader: begin
        p = pr_hdr_idx;
        case (p)
          8'd4:  pr_fmagic[7:0] = b;
          8'd5:  pr_fmagic[15:8] = b;
          8'd8:  pr_width[7:0] = b;
          8'd9:  pr_width[15:8] = b;
          8'd10: pr_height[7:0] = b;
          8'd11: pr_height[15:8] = b;
          8'd16: pr_speed[7:0] = b;
          8'd17: pr_speed[15:8] = b;
          8'd18: pr_speed[23:16] = b;
          8'd19: pr_speed[31:24] = b;
          default: ;
        endcase
        if (p >= 8'd12 && p <= 8'd17) pr_pre[p - 8'd12] = b;
        pr_hdr_idx = p + 8'd1;
        if (p == ShortDecPos && pr_speed[15:0] == MagicFrame) begin
          if (pr_width == '0 || pr_height == '0) begin
            push_fault(FaultDim);
          end else begin
            pr_rate = RateSlow;
            pr_ticks = 32'd1;
            push_header();
            finish_preamble();
          end
        end else if (p == HeaderLastPos) begin
          if (pr_width == '0 || pr_height == '0) begin
            push_fault(FaultDim);
          end else if (pr_fmagic != MagicFli && pr_fmagic != MagicFlc) begin
            push_fault(FaultMagic);
          end else begin
            pr_rate = (pr_fmagic == MagicFli) ? RateFli : RateFlc;
            pr_ticks = pr_speed;
            if (pr_ticks == '0) begin
              pr_rate = RateSlow;
              pr_ticks = 32'd1;
            end
            push_header();
          end
        end
      end
      PhPreamble: begin
        pr_pre[pr_pre_idx] = b;
        pr_pre_idx = pr_pre_idx + 3'd1;
        if (pr_pre_idx == 3'd6) finish_preamble();
      end
      PhBody: begin
        is_last = (pr_remain <= 32'd1);
        if (pr_fwd) push_chunk_byte(b, is_last);
        if (pr_remain > '0) pr_remain = pr_remain - 32'd1;
        if (pr_remain == '0) begin
          if (pr_fwd) pr_pts = pr_pts + {32'd0, pr_ticks};
          pr_fwd = 1'b0;
          pr_pre_idx = '0;
          pr_phase = PhPreamble;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b, input bit sof);
    stream_b.push_back(b);
    stream_sof.push_back(sof);
  endtask

  task automatic append_body(input logic [31:0] csize);
    int n;
    int i;
    n = 0;
    if (csize > PreambleLen) n = (csize - PreambleLen > BodyCap) ? BodyCap : int'(csize - PreambleLen);
    for (i = 0; i < n; i++) add_byte($urandom_range(255), 1'b0);
  endtask

  task automatic gen_file(input logic short_hdr, input logic [15:0] fmagic,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [31:0] spd, input logic [31:0] first_size);
    int i;
    logic [7:0] b;
    for (i = 0; i < (short_hdr ? 18 : 128); i++) begin
      b = $urandom_range(255);
      case (i)
        4:  b = fmagic[7:0];
        5:  b = fmagic[15:8];
        8:  b = w[7:0];
        9:  b = w[15:8];
        10: b = h[7:0];
        11: b = h[15:8];
        12: if (short_hdr) b = first_size[7:0];
        13: if (short_hdr) b = first_size[15:8];
        14: if (short_hdr) b = first_size[23:16];
        15: if (short_hdr) b = first_size[31:24];
        16: b = short_hdr ? MagicFrame[7:0] : spd[7:0];
        17: b = short_hdr ? MagicFrame[15:8] : spd[15:8];
        18: b = spd[23:16];
        19: b = spd[31:24];
        default: ;
      endcase
      add_byte(b, i == 0);
    end
    if (short_hdr) append_body(first_size);
  endtask

  task automatic gen_chunk(input logic [31:0] csize, input logic [15:0] cmagic);
    add_byte(csize[7:0], 1'b0);
    add_byte(csize[15:8], 1'b0);
    add_byte(csize[23:16], 1'b0);
    add_byte(csize[31:24], 1'b0);
    add_byte(cmagic[7:0], 1'b0);
    add_byte(cmagic[15:8], 1'b0);
    append_body(csize);
  endtask

  function automatic logic [31:0] pick_chunk_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return PreambleLen;
    if (r < 18) return $urandom_range(5);
    if (r < 25) return $urandom | 32'h100;
    return $urandom_range(7, 20);
  endfunction

  task automatic gen_random_file();
    int sel;
    int n;
    int i;
    logic sh;
    logic [15:0] fm;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] spd;
    sel = $urandom_range(99);
    if (sel < 8) begin
      n = $urandom_range(1, 30);
      for (i = 0; i < n; i++) add_byte($urandom_range(255), (i == 0) && $urandom_range(1));
    end else begin
      sh = (sel < 82);
      w = $urandom_range(65535);
      h = $urandom_range(65535);
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) w = '0;
        else h = '0;
      end
      n = $urandom_range(99);
      fm = (n < 45) ? MagicFli : (n < 90) ? MagicFlc : 16'($urandom_range(65535));
      spd = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      if (spd[15:0] == MagicFrame) spd[0] = ~spd[0];
      gen_file(sh, fm, w, h, spd, pick_chunk_size());
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        gen_chunk(pick_chunk_size(),
                  ($urandom_range(9) < 7) ? ($urandom_range(1) ? MagicFrame : MagicPrefix)
                                          : 16'($urandom_range(65535)));
      end
      if ($urandom_range(6) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          void'(stream_b.pop_back());
          void'(stream_sof.pop_back());
        end
      end
    end
  endtask

  task automatic send_stream();
    int i;
    int prior;
    for (i = 0; i < stream_b.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      data_byte_i <= stream_b[i];
      starts_file_i <= stream_sof[i];
      do @(posedge clk_i); while (!in_ready_o);
      prior = pending_words.size();
      predict_deframe(stream_b[i], stream_sof[i]);
      if (i == typed_idx && pending_words.size() > prior) pending_words[prior] = typed_word;
      @(negedge clk_i);
    end
    stream_b.delete();
    stream_sof.delete();
    typed_idx = -1;
  endtask

  task automatic run_random(input int budget);
    while (stream_b.size() < budget) gen_random_file();
    send_stream();
  endtask

  task automatic settle_outputs();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      fail_cnt++;
      if (fail_cnt <= 40) $display("%0t: %s expected %0h got %0h", $time, name, e, a);
    end
  endtask

  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      out_ready_i <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 40) $display("%0t: unexpected word, kind %0d", $time, kind_o);
      end else begin
        seen_exp = pending_words.pop_front();
        check_field("kind", seen_exp.kind, kind_o);
        check_field("chunk_byte", seen_exp.data, chunk_byte_o);
        check_field("last_of_chunk", seen_exp.is_last, last_of_chunk_o);
        check_field("frame_pts", seen_exp.pts, frame_pts_o);
        check_field("tick_rate", seen_exp.rate, tick_rate_o);
        check_field("frame_width", seen_exp.width, frame_width_o);
        check_field("frame_height", seen_exp.height, frame_height_o);
        check_field("ticks_per_frame", seen_exp.ticks, ticks_per_frame_o);
        check_field("fault", seen_exp.fault, fault_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("flic_container_deframer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int r;
    file_row_t row;
    dir_rows[0]  = '{1'b0, MagicFli, 16'd320, 16'd200, 32'd5, 32'd10, MagicFrame,
                     32'd9, 16'h1234, 32'd6, MagicPrefix, KindHeader, RateFli, 32'd5, FaultNone};
    dir_rows[1]  = '{1'b0, MagicFlc, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd7, MagicFrame,
                     32'd8, MagicPrefix, 32'd7, MagicFrame, KindHeader, RateFlc, 32'hFFFF_FFFF,
                     FaultNone};
    dir_rows[2]  = '{1'b0, MagicFlc, 16'd1, 16'd1, 32'd0, 32'd6, 16'h0000, 32'd9, MagicFrame,
                     32'd7, 16'hFFFF, KindHeader, RateSlow, 32'd1, FaultNone};
    dir_rows[3]  = '{1'b0, MagicFli, 16'd0, 16'd10, 32'd3, 32'd8, MagicFrame, 32'd6, MagicFrame,
                     32'd6, MagicFrame, KindError, 10'd0, 32'd0, FaultDim};
    dir_rows[4]  = '{1'b0, 16'h1234, 16'd5, 16'd0, 32'd3, 32'd8, MagicFrame, 32'd6, MagicFrame,
                     32'd6, MagicFrame, KindError, 10'd0, 32'd0, FaultDim};
    dir_rows[5]  = '{1'b0, 16'h0000, 16'd1, 16'd1, 32'd3, 32'd8, MagicFrame, 32'd6, MagicFrame,
                     32'd6, MagicFrame, KindError, 10'd0, 32'd0, FaultMagic};
    dir_rows[6]  = '{1'b0, MagicFlc, 16'd1, 16'd1, 32'h0001_0000, 32'd3, MagicFrame, 32'd8,
                     MagicFrame, 32'd6, MagicFrame, KindHeader, RateFlc, 32'h0001_0000, FaultNone};
    dir_rows[7]  = '{1'b1, 16'h0000, 16'd64, 16'd48, 32'd0, 32'd8, MagicFrame, 32'd5, MagicFrame,
                     32'd7, MagicFrame, KindHeader, RateSlow, 32'd1, FaultNone};
    dir_rows[8]  = '{1'b1, 16'h0000, 16'd1, 16'd1, 32'd0, 32'd6, MagicFrame, 32'd7, MagicPrefix,
                     32'd6, MagicFrame, KindHeader, RateSlow, 32'd1, FaultNone};
    dir_rows[9]  = '{1'b1, 16'h0000, 16'd0, 16'd7, 32'd0, 32'd8, MagicFrame, 32'd7, MagicFrame,
                     32'd6, MagicFrame, KindError, 10'd0, 32'd0, FaultDim};
    dir_rows[10] = '{1'b1, 16'h0000, 16'hFFFF, 16'd1, 32'd0, 32'd0, MagicFrame, 32'd7,
                     MagicFrame, 32'd6, MagicFrame, KindHeader, RateSlow, 32'd1, FaultNone};
    dir_rows[11] = '{1'b0, MagicFli, 16'd2, 16'd2, 32'd1, 32'hFFFF_FFFF, MagicFrame, 32'd7,
                     MagicFrame, 32'd6, MagicFrame, KindHeader, RateFli, 32'd1, FaultNone};
    dir_rows[12] = '{1'b0, MagicFlc, 16'd3, 16'd3, 32'd2, 32'h8000_0000, 16'h00AA, 32'd7,
                     MagicFrame, 32'd6, MagicFrame, KindHeader, RateFlc, 32'd2, FaultNone};
    pr_reset();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle = 23;
    recv_idle = 82;
    for (r = 0; r < NumRows; r++) begin
      row = dir_rows[r];
      gen_file(row.short_hdr, row.fmagic, row.w, row.h, row.spd, row.size_a);
      if (!row.short_hdr) gen_chunk(row.size_a, row.mag_a);
      gen_chunk(row.size_b, row.mag_b);
      gen_chunk(row.size_c, row.mag_c);
      typed_idx = row.short_hdr ? int'(ShortDecPos) : int'(HeaderLastPos);
      typed_word = '0;
      typed_word.kind = row.exp_kind;
      if (row.exp_kind == KindHeader) begin
        typed_word.rate = row.exp_rate;
        typed_word.width = row.w;
        typed_word.height = row.h;
        typed_word.ticks = row.exp_ticks;
      end else begin
        typed_word.fault = row.exp_fault;
      end
      send_stream();
    end
    run_random(120);
    in_valid_i <= 1'b0;
    settle_outputs();
    @(negedge clk_i);

    send_idle = 82;
    recv_idle = 23;
    run_random(120);
    in_valid_i <= 1'b0;
    settle_outputs();
    @(negedge clk_i);

    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    gen_file(1'b1, 16'h0000, 16'd9, 16'd9, 32'd0, 32'd30);
    run_random(120);
    in_valid_i <= 1'b0;
    settle_outputs();

    if (fail_cnt == 0) begin
      $display("flic_container_deframer_tb: done, clean");
    end else begin
      $display("flic_container_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
